[rtl/pfc_pkg.sv]
// shared types, microcode table and cell arithmetic for the playfair cipher unit
package pfc_pkg;

	// fixed sizes of the key square and the alphabet
	localparam int unsigned SqCells = 25;
	localparam int unsigned Alpha   = 26;
	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_Z = 5'd25;
	localparam logic [4:0] LAST_CELL = 5'd25;

	// command codes
	localparam logic [1:0] CMD_KEY     = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_ENCRYPT = 2'd2;
	localparam logic [1:0] CMD_DECRYPT = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] letter_a;
		logic [4:0] letter_b;
	} item_t;

	typedef struct packed {
		logic [4:0] out_a;
		logic [4:0] out_b;
		logic       not_ready;
	} result_t;

	// datapath action of one microcode step
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_FETCH,
		ACT_PLACE_KEY,
		ACT_PLACE_SCAN,
		ACT_SET_READY,
		ACT_READ_MAP_A,
		ACT_READ_MAP_B,
		ACT_CALC,
		ACT_READ_SQ_A,
		ACT_READ_SQ_B,
		ACT_CAPT_B,
		ACT_SET_NR,
		ACT_EMIT
	} act_t;

	// jump condition of one microcode step
	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_PAIR,
		COND_FINISH,
		COND_SCAN_MORE,
		COND_NOT_READY
	} cond_t;

	typedef struct packed {
		act_t       act;
		cond_t      cond;
		logic [3:0] target;
	} uword_t;

	// program addresses
	localparam logic [3:0] STEP_FETCH     = 4'd0;
	localparam logic [3:0] STEP_DISPATCH  = 4'd1;
	localparam logic [3:0] STEP_KEY_OR_FN = 4'd2;
	localparam logic [3:0] STEP_KEY       = 4'd3;
	localparam logic [3:0] STEP_SCAN      = 4'd4;
	localparam logic [3:0] STEP_READY     = 4'd5;
	localparam logic [3:0] STEP_MAP_A     = 4'd6;
	localparam logic [3:0] STEP_MAP_B     = 4'd7;
	localparam logic [3:0] STEP_CALC      = 4'd8;
	localparam logic [3:0] STEP_SQ_A      = 4'd9;
	localparam logic [3:0] STEP_SQ_B      = 4'd10;
	localparam logic [3:0] STEP_CAPT_B    = 4'd11;
	localparam logic [3:0] STEP_NR        = 4'd12;
	localparam logic [3:0] STEP_EMIT      = 4'd13;

	// microcode rom: a taken condition jumps to target, otherwise step + 1
	function automatic uword_t ucode(input logic [3:0] pc);
		uword_t w;
		case (pc)
			STEP_FETCH:     w = '{ACT_FETCH,      COND_NONE,      STEP_FETCH};
			STEP_DISPATCH:  w = '{ACT_NOP,        COND_PAIR,      STEP_MAP_A};
			STEP_KEY_OR_FN: w = '{ACT_NOP,        COND_FINISH,    STEP_SCAN};
			STEP_KEY:       w = '{ACT_PLACE_KEY,  COND_ALWAYS,    STEP_FETCH};
			STEP_SCAN:      w = '{ACT_PLACE_SCAN, COND_SCAN_MORE, STEP_SCAN};
			STEP_READY:     w = '{ACT_SET_READY,  COND_ALWAYS,    STEP_FETCH};
			STEP_MAP_A:     w = '{ACT_READ_MAP_A, COND_NOT_READY, STEP_NR};
			STEP_MAP_B:     w = '{ACT_READ_MAP_B, COND_NONE,      STEP_FETCH};
			STEP_CALC:      w = '{ACT_CALC,       COND_NONE,      STEP_FETCH};
			STEP_SQ_A:      w = '{ACT_READ_SQ_A,  COND_NONE,      STEP_FETCH};
			STEP_SQ_B:      w = '{ACT_READ_SQ_B,  COND_NONE,      STEP_FETCH};
			STEP_CAPT_B:    w = '{ACT_CAPT_B,     COND_ALWAYS,    STEP_EMIT};
			STEP_NR:        w = '{ACT_SET_NR,     COND_NONE,      STEP_FETCH};
			STEP_EMIT:      w = '{ACT_EMIT,       COND_ALWAYS,    STEP_FETCH};
			default:        w = '{ACT_NOP,        COND_ALWAYS,    STEP_FETCH};
		endcase
		return w;
	endfunction

	// pair letter: saturate to z, then read j as i
	function automatic logic [4:0] pair_letter(input logic [4:0] l);
		logic [4:0] s;
		s = (l > LETTER_Z) ? LETTER_Z : l;
		return (s == LETTER_J) ? LETTER_I : s;
	endfunction

	// row of a cell, by compare chain instead of a divide
	function automatic logic [2:0] cell_row(input logic [4:0] c);
		logic [2:0] r;
		if (c >= 5'd20) r = 3'd4;
		else if (c >= 5'd15) r = 3'd3;
		else if (c >= 5'd10) r = 3'd2;
		else if (c >= 5'd5) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	function automatic logic [4:0] row_base(input logic [2:0] r);
		return {r, 2'b00} + {2'b00, r};
	endfunction

	function automatic logic [2:0] cell_col(input logic [4:0] c);
		logic [4:0] d;
		d = c - row_base(cell_row(c));
		return d[2:0];
	endfunction

	// one step around a row or column of five, forward or back
	function automatic logic [2:0] wrap5(input logic [2:0] v, input logic back);
		logic [2:0] r;
		if (back) r = (v == 3'd0) ? 3'd4 : v - 3'd1;
		else r = (v == 3'd4) ? 3'd0 : v + 3'd1;
		return r;
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] k);
		return row_base(r) + {2'b00, k};
	endfunction

endpackage

[rtl/pfc_ram.sv]
// generic single write, single registered read ram
module pfc_ram #(
	parameter int Width = 5,
	parameter int Depth = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/playfair_digraph_cipher_unit.sv]
// playfair 5x5 digraph cipher: key square build and pair encrypt/decrypt
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item     | item_valid / item_ready     | item_t   cmd, letter_a, letter_b
//  result   | result_valid / result_ready | result_t out_a, out_b, not_ready
//
// a microcoded sequencer runs one control word per cycle unless it holds at fetch or emit;
// items are taken one at a time. key letter: fetch, dispatch, key-or-finish and key steps;
// finish: one alphabet letter scanned per cycle, ending at once if the square is finished;
// pair: the letter map, then the square ram, each read through its single read port;
// pair before finish: a not-ready result. a full result register waits at the emit step.
// arst_n clears the sequencer, fill count, used bits and ready flag; the rams need no clear.
module playfair_digraph_cipher_unit
	import pfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// sequencer and control state
	logic [3:0]  pc_q, pc_d;
	uword_t      uw;
	logic        stall, cond_hit;
	logic [4:0]  fill_q;
	logic [4:0]  scan_q;
	logic        ready_q;
	logic [25:0] used_q;
	logic        result_valid_q;

	// payload registers
	item_t       item_q;
	logic [4:0]  ca_q, na_q, nb_q;
	logic [4:0]  res_a_q, res_b_q;
	logic        res_nr_q;
	result_t     result_q;

	// datapath signals
	logic [4:0]  place_l;
	logic        place_ok;
	logic        wr_en;
	logic [4:0]  map_raddr, map_rdata;
	logic [4:0]  sq_raddr, sq_rdata;
	logic [2:0]  ra, ka, rb, kb;
	logic        back;
	logic [4:0]  na_d, nb_d;
	logic        emit_fire;

	// next step and handshake control
	always_comb begin
		uw = ucode(pc_q);
		stall = ((uw.act == ACT_FETCH) && !item_valid)
			|| ((uw.act == ACT_EMIT) && result_valid_q && !result_ready);
		case (uw.cond)
			COND_NONE:      cond_hit = 1'b0;
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_PAIR:      cond_hit = (item_q.cmd == CMD_ENCRYPT) || (item_q.cmd == CMD_DECRYPT);
			COND_FINISH:    cond_hit = (item_q.cmd == CMD_FINISH);
			COND_SCAN_MORE: cond_hit = !ready_q && (scan_q != LAST_CELL);
			COND_NOT_READY: cond_hit = !ready_q;
			default:        cond_hit = 1'b0;
		endcase
		if (stall) begin
			pc_d = pc_q;
		end else if (cond_hit) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end

	assign item_ready = (uw.act == ACT_FETCH);
	assign emit_fire = (uw.act == ACT_EMIT) && !stall;

	// letter placement, shared by key letters and the finish scan
	always_comb begin
		place_l = (uw.act == ACT_PLACE_SCAN) ? scan_q : item_q.letter_a;
		place_ok = ((uw.act == ACT_PLACE_KEY) || (uw.act == ACT_PLACE_SCAN))
			&& !ready_q && (place_l < LAST_CELL + 5'd1) && (place_l != LETTER_J)
			&& !used_q[place_l];
		wr_en = place_ok && (fill_q < LAST_CELL);
	end

	// ram read addresses
	always_comb begin
		map_raddr = (uw.act == ACT_READ_MAP_B) ? pair_letter(item_q.letter_b)
			: pair_letter(item_q.letter_a);
		sq_raddr = (uw.act == ACT_READ_SQ_B) ? nb_q : na_q;
	end

	// target cells from the two source cells
	always_comb begin
		ra = cell_row(ca_q);
		ka = cell_col(ca_q);
		rb = cell_row(map_rdata);
		kb = cell_col(map_rdata);
		back = (item_q.cmd == CMD_DECRYPT);
		if (ca_q == map_rdata) begin
			na_d = ca_q;
			nb_d = map_rdata;
		end else if (ra == rb) begin
			na_d = cell_of(ra, wrap5(ka, back));
			nb_d = cell_of(rb, wrap5(kb, back));
		end else if (ka == kb) begin
			na_d = cell_of(wrap5(ra, back), ka);
			nb_d = cell_of(wrap5(rb, back), kb);
		end else begin
			na_d = cell_of(ra, kb);
			nb_d = cell_of(rb, ka);
		end
	end

	// square: cell -> letter
	pfc_ram #(.Width(5), .Depth(SqCells)) u_square (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q),
		.wdata (place_l),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	// letter map: letter -> cell
	pfc_ram #(.Width(5), .Depth(Alpha)) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (place_l),
		.wdata (fill_q),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
			fill_q <= '0;
			scan_q <= '0;
			ready_q <= 1'b0;
			used_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (place_ok) begin
				used_q[place_l] <= 1'b1;
			end
			if (wr_en) begin
				fill_q <= fill_q + 5'd1;
			end
			if (uw.act == ACT_PLACE_SCAN) begin
				scan_q <= scan_q + 5'd1;
			end else if (uw.act == ACT_SET_READY) begin
				scan_q <= '0;
			end
			if (uw.act == ACT_SET_READY) begin
				ready_q <= 1'b1;
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (emit_fire) begin
				result_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (uw.act == ACT_READ_MAP_B) begin
			ca_q <= map_rdata;
		end
		if (uw.act == ACT_CALC) begin
			na_q <= na_d;
			nb_q <= nb_d;
		end
		if (uw.act == ACT_READ_SQ_B) begin
			res_a_q <= sq_rdata;
		end
		if (uw.act == ACT_CAPT_B) begin
			res_b_q <= sq_rdata;
			res_nr_q <= 1'b0;
		end
		if (uw.act == ACT_SET_NR) begin
			res_a_q <= '0;
			res_b_q <= '0;
			res_nr_q <= 1'b1;
		end
		if (emit_fire) begin
			result_q <= '{out_a: res_a_q, out_b: res_b_q, not_ready: res_nr_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// a new result beat only appears out of the emit step
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(pc_q == STEP_EMIT))
		else $error("result valid rose outside the emit step");

	// a not-ready result carries zero letters
	a_nr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.not_ready) |-> (result_q.out_a == '0 && result_q.out_b == '0))
		else $error("not-ready result with nonzero letters");

	// a finished square holds all 25 cells
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (fill_q == LAST_CELL))
		else $error("square marked ready before it is full");

	// items are taken only at the fetch step
	a_fetch_only: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (pc_q == STEP_FETCH))
		else $error("item ready outside the fetch step");

endmodule

[sim/tb.sv]
// testbench for the playfair digraph cipher unit: key square build and pair rules
`timescale 1ns / 100ps

module tb;
	import pfc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PAIRS = 1200;
	localparam int unsigned DRAIN_CYCLES = 40;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// cipher state as the block should hold it
	logic [4:0]  key_square [SqCells];
	bit          letter_placed [Alpha];
	int unsigned cells_filled;
	bit          square_sealed;

	result_t     pending_pairs [$];
	int unsigned items_sent;
	int unsigned pairs_checked;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned hold_request;
	bit          quiet_stretch;

	playfair_digraph_cipher_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d pair results still owed", cycle_count,
			pending_pairs.size());
		$display("Simulation FAILED");
		$finish;
	end

	// append one letter to the square and mark it used
	function automatic void seat_letter(input logic [4:0] l);
		if (cells_filled < SqCells) begin
			key_square[cells_filled] = l;
			cells_filled++;
		end
		letter_placed[l] = 1'b1;
	endfunction

	// pair letter as the cipher sees it: clamp to z, j reads as i
	function automatic logic [4:0] fold_letter(input logic [4:0] l);
		logic [4:0] s;
		s = (l > LETTER_Z) ? LETTER_Z : l;
		return (s == LETTER_J) ? LETTER_I : s;
	endfunction

	function automatic int cell_holding(input logic [4:0] l);
		for (int k = 0; k < SqCells; k++)
			if (key_square[k] == l) return k;
		return 0;
	endfunction

	// advance the cipher state by one accepted beat; returns 1 when a result is due
	function automatic bit predict_item(input item_t it, output result_t r);
		int ca, cb, ra, rb, ka, kb, na, nb, step;
		r = '0;
		case (it.cmd)
			CMD_KEY: begin
				if (!square_sealed && it.letter_a < Alpha && it.letter_a != LETTER_J &&
						!letter_placed[it.letter_a])
					seat_letter(it.letter_a);
				return 1'b0;
			end
			CMD_FINISH: begin
				if (!square_sealed) begin
					for (int k = 0; k < Alpha; k++)
						if (k != LETTER_J && !letter_placed[k]) seat_letter(k[4:0]);
					square_sealed = 1'b1;
				end
				return 1'b0;
			end
			default: ;
		endcase
		if (!square_sealed) begin
			r.not_ready = 1'b1;
			return 1'b1;
		end
		ca = cell_holding(fold_letter(it.letter_a));
		cb = cell_holding(fold_letter(it.letter_b));
		ra = ca / 5;
		ka = ca % 5;
		rb = cb / 5;
		kb = cb % 5;
		step = (it.cmd == CMD_ENCRYPT) ? 1 : 4;
		if (ca == cb) begin
			na = ca;
			nb = cb;
		end else if (ra == rb) begin
			na = ra * 5 + (ka + step) % 5;
			nb = rb * 5 + (kb + step) % 5;
		end else if (ka == kb) begin
			na = ((ra + step) % 5) * 5 + ka;
			nb = ((rb + step) % 5) * 5 + kb;
		end else begin
			na = ra * 5 + kb;
			nb = rb * 5 + ka;
		end
		r.out_a = key_square[na];
		r.out_b = key_square[nb];
		return 1'b1;
	endfunction

	// compare one result beat against the oldest owed pair
	function automatic void check_result(input result_t got);
		result_t want;
		if (pending_pairs.size() == 0) begin
			$display("%0t: unexpected result beat out_a=%0d out_b=%0d not_ready=%0d", $time,
				got.out_a, got.out_b, got.not_ready);
			mismatch_count++;
			return;
		end
		want = pending_pairs.pop_front();
		pairs_checked++;
		if (got.out_a !== want.out_a) begin
			$display("%0t: out_a expected %0d actual %0d", $time, want.out_a, got.out_a);
			mismatch_count++;
		end
		if (got.out_b !== want.out_b) begin
			$display("%0t: out_b expected %0d actual %0d", $time, want.out_b, got.out_b);
			mismatch_count++;
		end
		if (got.not_ready !== want.not_ready) begin
			$display("%0t: not_ready expected %0d actual %0d", $time, want.not_ready,
				got.not_ready);
			mismatch_count++;
		end
	endfunction

	// result sink: random stalls, quiet stretches and the long hold on request
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = quiet_stretch ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_result(result);
		end
	end

	function automatic item_t make_item(input logic [1:0] cmd, input logic [4:0] a,
			input logic [4:0] b);
		item_t it;
		it.cmd = cmd;
		it.letter_a = a;
		it.letter_b = b;
		return it;
	endfunction

	// mostly real letters, now and then 26..31
	function automatic logic [4:0] random_letter();
		return ($urandom_range(0, 6) == 0) ? 5'($urandom_range(26, 31))
			: 5'($urandom_range(0, 25));
	endfunction

	// random pair, often steered onto a shared row or column of the square
	function automatic item_t random_pair();
		item_t it;
		int ca, cb;
		it.cmd = $urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT;
		it.letter_a = random_letter();
		ca = cell_holding(fold_letter(it.letter_a));
		case ($urandom_range(0, 3))
			0: cb = (ca / 5) * 5 + $urandom_range(0, 4);
			1: cb = $urandom_range(0, 4) * 5 + ca % 5;
			default: cb = -1;
		endcase
		it.letter_b = (cb >= 0) ? key_square[cb] : random_letter();
		return it;
	endfunction

	// offer one beat after a random gap and hold it until taken
	task automatic send_item(input item_t it);
		int unsigned gap;
		result_t r;
		gap = quiet_stretch ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		if (predict_item(it, r)) pending_pairs.push_back(r);
	endtask

	// idle the input and wait until every owed result is back
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_pairs.size() != 0);
	endtask

	// pairs before the square exists
	task automatic test_early_pairs();
		send_item(make_item(CMD_ENCRYPT, 5'd0, 5'd25));
		send_item(make_item(CMD_DECRYPT, 5'd31, LETTER_J));
	endtask

	// key stream: z, j skipped, a, repeated z, out of range, then random letters
	task automatic test_key_entry();
		send_item(make_item(CMD_KEY, LETTER_Z, 5'd31));
		send_item(make_item(CMD_KEY, LETTER_J, 5'd0));
		send_item(make_item(CMD_KEY, 5'd0, 5'd21));
		send_item(make_item(CMD_KEY, LETTER_Z, 5'd10));
		send_item(make_item(CMD_KEY, 5'd31, 5'd31));
		send_item(make_item(CMD_KEY, 5'd26, 5'd0));
		repeat (10) send_item(make_item(CMD_KEY, 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31))));
	endtask

	// finish, a second finish and a late key letter, both to be ignored
	task automatic test_finish();
		send_item(make_item(CMD_FINISH, 5'd31, 5'd31));
		send_item(make_item(CMD_FINISH, 5'd0, 5'd0));
		send_item(make_item(CMD_KEY, 5'd1, 5'd31));
	endtask

	// each placement rule in both directions, with wrap, j and out of range letters
	task automatic test_pair_rules();
		send_item(make_item(CMD_ENCRYPT, key_square[7], key_square[7]));
		send_item(make_item(CMD_DECRYPT, key_square[7], key_square[7]));
		send_item(make_item(CMD_ENCRYPT, key_square[0], key_square[4]));
		send_item(make_item(CMD_DECRYPT, key_square[20], key_square[24]));
		send_item(make_item(CMD_ENCRYPT, key_square[2], key_square[22]));
		send_item(make_item(CMD_DECRYPT, key_square[4], key_square[19]));
		send_item(make_item(CMD_ENCRYPT, key_square[6], key_square[18]));
		send_item(make_item(CMD_DECRYPT, key_square[24], key_square[0]));
		send_item(make_item(CMD_ENCRYPT, LETTER_J, LETTER_I));
		send_item(make_item(CMD_DECRYPT, LETTER_J, key_square[12]));
		send_item(make_item(CMD_ENCRYPT, 5'd31, 5'd26));
		send_item(make_item(CMD_DECRYPT, 5'd0, 5'd27));
	endtask

	// sink holds off for a long stretch while beats keep coming
	task automatic test_result_backpressure();
		drain_results();
		quiet_stretch = 1'b1;
		hold_request = 200;
		repeat (16) send_item(random_pair());
		quiet_stretch = 1'b0;
		drain_results();
	endtask

	// random pairs with ignored commands mixed in, idle and quiet stretches
	task automatic test_random_traffic();
		int unsigned pairs;
		pairs = 0;
		while (pairs < RANDOM_PAIRS) begin
			if (pairs % 100 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
			if (pairs == RANDOM_PAIRS / 2) drain_results();
			if ($urandom_range(0, 11) == 0) begin
				send_item(make_item($urandom_range(0, 1) ? CMD_KEY : CMD_FINISH,
					5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))));
			end else begin
				send_item(random_pair());
				pairs++;
			end
		end
		quiet_stretch = 1'b0;
	endtask

	// reset, test sequence, final report
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_early_pairs();
		test_key_entry();
		test_finish();
		test_pair_rules();
		test_result_backpressure();
		test_random_traffic();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d beats, checked %0d pair results, %0d mismatches", items_sent,
			pairs_checked, mismatch_count);
		$display("covered early pairs, key build, finish, all pair rules and a long hold");
		if (mismatch_count == 0 && pending_pairs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
